>>> src/triangle_cell_index_assert.svh
// ----------------------------------------------------------------------------
// triangle cell index assertion macros
// shared property forms for the triangle cell index block
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_CELL_INDEX_ASSERT_SVH
`define TRIANGLE_CELL_INDEX_ASSERT_SVH

// same-cycle implication
`define TCI_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("triangle cell index: implication check failed");

// implication after a fixed number of cycles
`define TCI_ASSERT_DLY(label, clk, rst, ante, dly, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error("triangle cell index: latency check failed");

`endif

>>> src/tci_pkg.sv
// ----------------------------------------------------------------------------
// tci_pkg
// shared constants, register codes and control types of the triangle cell index
// ----------------------------------------------------------------------------
package tci_pkg;

   localparam int COORD_WIDTH_DEF   = 16;
   localparam int MAX_DIVISIONS_DEF = 64;

   localparam int DIV_W      = 7;
   localparam int BAND_W     = 7;
   localparam int IDX_W      = 13;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam int VERTEX_A_X_RST = 0;
   localparam int VERTEX_A_Y_RST = 0;
   localparam int VERTEX_B_X_RST = 256;
   localparam int VERTEX_B_Y_RST = 0;
   localparam int VERTEX_C_X_RST = 0;
   localparam int VERTEX_C_Y_RST = 256;
   localparam int DIVISIONS_RST  = 10;

   typedef enum logic [2:0] {
      REG_VERTEX_A_X = 3'd0,
      REG_VERTEX_A_Y = 3'd1,
      REG_VERTEX_B_X = 3'd2,
      REG_VERTEX_B_Y = 3'd3,
      REG_VERTEX_C_X = 3'd4,
      REG_VERTEX_C_Y = 3'd5,
      REG_DIVISIONS  = 3'd6
   } csr_reg_type;

   typedef struct packed {
      logic valid;
      logic degenerate;
      logic outside;
   } tci_ctrl_type;

endpackage

>>> src/tci_csr.sv
// ----------------------------------------------------------------------------
// tci_csr
// configuration registers: triangle vertices and divisions per side
// ----------------------------------------------------------------------------
module tci_csr #(
   parameter int COORD_WIDTH   = tci_pkg::COORD_WIDTH_DEF,
   parameter int MAX_DIVISIONS = tci_pkg::MAX_DIVISIONS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tci_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [tci_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [tci_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready,
   output logic [COORD_WIDTH-1:0]              vertex_a_x,
   output logic [COORD_WIDTH-1:0]              vertex_a_y,
   output logic [COORD_WIDTH-1:0]              vertex_b_x,
   output logic [COORD_WIDTH-1:0]              vertex_b_y,
   output logic [COORD_WIDTH-1:0]              vertex_c_x,
   output logic [COORD_WIDTH-1:0]              vertex_c_y,
   output logic [$clog2(MAX_DIVISIONS+1)-1:0]  divisions_eff
);
   import tci_pkg::*;

   localparam int NBW = $clog2(MAX_DIVISIONS + 1);

   logic [COORD_WIDTH-1:0] ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff;
   logic [COORD_WIDTH-1:0] ax_in, ay_in, bx_in, by_in, cx_in, cy_in;
   logic [DIV_W-1:0]       div_ff, div_in;
   logic                   wr_en;
   csr_reg_type            reg_sel;

   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = csr_reg_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_pready = 1'b1;

   always_comb begin
      ax_in  = ax_ff;
      ay_in  = ay_ff;
      bx_in  = bx_ff;
      by_in  = by_ff;
      cx_in  = cx_ff;
      cy_in  = cy_ff;
      div_in = div_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_VERTEX_A_X: ax_in  = csr_pwdata[COORD_WIDTH-1:0];
            REG_VERTEX_A_Y: ay_in  = csr_pwdata[COORD_WIDTH-1:0];
            REG_VERTEX_B_X: bx_in  = csr_pwdata[COORD_WIDTH-1:0];
            REG_VERTEX_B_Y: by_in  = csr_pwdata[COORD_WIDTH-1:0];
            REG_VERTEX_C_X: cx_in  = csr_pwdata[COORD_WIDTH-1:0];
            REG_VERTEX_C_Y: cy_in  = csr_pwdata[COORD_WIDTH-1:0];
            REG_DIVISIONS:  div_in = csr_pwdata[DIV_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ax_ff  <= COORD_WIDTH'(VERTEX_A_X_RST);
         ay_ff  <= COORD_WIDTH'(VERTEX_A_Y_RST);
         bx_ff  <= COORD_WIDTH'(VERTEX_B_X_RST);
         by_ff  <= COORD_WIDTH'(VERTEX_B_Y_RST);
         cx_ff  <= COORD_WIDTH'(VERTEX_C_X_RST);
         cy_ff  <= COORD_WIDTH'(VERTEX_C_Y_RST);
         div_ff <= DIV_W'(DIVISIONS_RST);
      end else begin
         ax_ff  <= ax_in;
         ay_ff  <= ay_in;
         bx_ff  <= bx_in;
         by_ff  <= by_in;
         cx_ff  <= cx_in;
         cy_ff  <= cy_in;
         div_ff <= div_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_VERTEX_A_X: csr_prdata = CSR_DATA_W'(ax_ff);
         REG_VERTEX_A_Y: csr_prdata = CSR_DATA_W'(ay_ff);
         REG_VERTEX_B_X: csr_prdata = CSR_DATA_W'(bx_ff);
         REG_VERTEX_B_Y: csr_prdata = CSR_DATA_W'(by_ff);
         REG_VERTEX_C_X: csr_prdata = CSR_DATA_W'(cx_ff);
         REG_VERTEX_C_Y: csr_prdata = CSR_DATA_W'(cy_ff);
         REG_DIVISIONS:  csr_prdata = CSR_DATA_W'(div_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // clamp to the largest supported division count
   always_comb begin
      if (32'(div_ff) > 32'(MAX_DIVISIONS)) begin
         divisions_eff = NBW'(MAX_DIVISIONS);
      end else begin
         divisions_eff = NBW'(div_ff);
      end
   end

   assign vertex_a_x = ax_ff;
   assign vertex_a_y = ay_ff;
   assign vertex_b_x = bx_ff;
   assign vertex_b_y = by_ff;
   assign vertex_c_x = cx_ff;
   assign vertex_c_y = cy_ff;

endmodule

>>> src/tci_cross.sv
// ----------------------------------------------------------------------------
// tci_cross
// edge vectors, cross products, orientation fix, scaling by n, inside test
// ----------------------------------------------------------------------------
module tci_cross #(
   parameter int COORD_WIDTH   = tci_pkg::COORD_WIDTH_DEF,
   parameter int MAX_DIVISIONS = tci_pkg::MAX_DIVISIONS_DEF
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             in_valid,
   input  logic signed [COORD_WIDTH-1:0]                    point_x,
   input  logic signed [COORD_WIDTH-1:0]                    point_y,
   input  logic signed [COORD_WIDTH-1:0]                    vertex_a_x,
   input  logic signed [COORD_WIDTH-1:0]                    vertex_a_y,
   input  logic signed [COORD_WIDTH-1:0]                    vertex_b_x,
   input  logic signed [COORD_WIDTH-1:0]                    vertex_b_y,
   input  logic signed [COORD_WIDTH-1:0]                    vertex_c_x,
   input  logic signed [COORD_WIDTH-1:0]                    vertex_c_y,
   input  logic [$clog2(MAX_DIVISIONS+1)-1:0]               divisions_eff,
   output tci_pkg::tci_ctrl_type                            out_ctrl,
   output logic [2*COORD_WIDTH+4+$clog2(MAX_DIVISIONS+1)-1:0] out_num_r,
   output logic [2*COORD_WIDTH+4+$clog2(MAX_DIVISIONS+1)-1:0] out_num_c,
   output logic [2*COORD_WIDTH+1:0]                         out_den
);
   import tci_pkg::*;

   localparam int DW  = COORD_WIDTH + 1;
   localparam int PW  = 2 * DW;
   localparam int XW  = PW + 1;
   localparam int NBW = $clog2(MAX_DIVISIONS + 1);
   localparam int SW  = XW + NBW + 1;

   tci_ctrl_type c1_ff, c2_ff, c3_ff, c4_ff, c5_ff, c6_ff;
   tci_ctrl_type c4_in, c6_in;

   // stage 1: vectors relative to vertex a
   logic signed [DW-1:0] dpx_ff, dpy_ff, d1x_ff, d1y_ff, d2x_ff, d2y_ff;
   // stage 2: products
   logic signed [PW-1:0] par0_ff, par1_ff, pac0_ff, pac1_ff, pd0_ff, pd1_ff;
   // stage 3: cross products
   logic signed [XW-1:0] ar_ff, ac_ff, den_ff;
   // stage 4: orientation fixed
   logic signed [XW-1:0] arn_ff, acn_ff, arn_in, acn_in;
   logic [XW-2:0]        dabs_ff, dabs_in;
   // stage 5: scaled by n
   logic signed [SW-1:0] nr_ff, nc_ff, nd_ff;
   logic [XW-2:0]        dabs5_ff;
   logic signed [NBW:0]  n_s;
   // stage 6
   logic signed [SW:0]   nsum;
   logic [SW-1:0]        num_r_ff, num_c_ff;
   logic [XW-2:0]        den6_ff;

   assign n_s = signed'({1'b0, divisions_eff});

   always_ff @(posedge clock) begin
      dpx_ff <= DW'(point_x) - DW'(vertex_a_x);
      dpy_ff <= DW'(point_y) - DW'(vertex_a_y);
      d1x_ff <= DW'(vertex_b_x) - DW'(vertex_a_x);
      d1y_ff <= DW'(vertex_b_y) - DW'(vertex_a_y);
      d2x_ff <= DW'(vertex_c_x) - DW'(vertex_a_x);
      d2y_ff <= DW'(vertex_c_y) - DW'(vertex_a_y);

      par0_ff <= PW'(dpx_ff) * PW'(d2y_ff);
      par1_ff <= PW'(dpy_ff) * PW'(d2x_ff);
      pac0_ff <= PW'(d1x_ff) * PW'(dpy_ff);
      pac1_ff <= PW'(d1y_ff) * PW'(dpx_ff);
      pd0_ff  <= PW'(d1x_ff) * PW'(d2y_ff);
      pd1_ff  <= PW'(d2x_ff) * PW'(d1y_ff);

      ar_ff  <= XW'(par0_ff) - XW'(par1_ff);
      ac_ff  <= XW'(pac0_ff) - XW'(pac1_ff);
      den_ff <= XW'(pd0_ff) - XW'(pd1_ff);

      arn_ff  <= arn_in;
      acn_ff  <= acn_in;
      dabs_ff <= dabs_in;

      nr_ff    <= SW'(arn_ff) * SW'(n_s);
      nc_ff    <= SW'(acn_ff) * SW'(n_s);
      nd_ff    <= SW'(signed'({1'b0, dabs_ff})) * SW'(n_s);
      dabs5_ff <= dabs_ff;

      num_r_ff <= nr_ff;
      num_c_ff <= nc_ff;
      den6_ff  <= dabs5_ff;
   end

   // clockwise triangles flip all three signs
   always_comb begin
      c4_in            = c3_ff;
      c4_in.degenerate = (den_ff == '0);
      if (den_ff[XW-1]) begin
         arn_in  = -ar_ff;
         acn_in  = -ac_ff;
         dabs_in = (XW-1)'(-den_ff);
      end else begin
         arn_in  = ar_ff;
         acn_in  = ac_ff;
         dabs_in = (XW-1)'(den_ff);
      end
   end

   assign nsum = (SW+1)'(nr_ff) + (SW+1)'(nc_ff);

   always_comb begin
      c6_in         = c5_ff;
      c6_in.outside = ~c5_ff.degenerate &
                      (nr_ff[SW-1] | nc_ff[SW-1] | (nsum > (SW+1)'(nd_ff)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
         c2_ff <= '0;
         c3_ff <= '0;
         c4_ff <= '0;
         c5_ff <= '0;
         c6_ff <= '0;
      end else begin
         c1_ff <= '{valid: in_valid, degenerate: 1'b0, outside: 1'b0};
         c2_ff <= c1_ff;
         c3_ff <= c2_ff;
         c4_ff <= c4_in;
         c5_ff <= c4_ff;
         c6_ff <= c6_in;
      end
   end

   assign out_ctrl  = c6_ff;
   assign out_num_r = num_r_ff;
   assign out_num_c = num_c_ff;
   assign out_den   = den6_ff;

endmodule

>>> src/tci_divider.sv
// ----------------------------------------------------------------------------
// tci_divider
// pipelined restoring divider, one quotient bit per stage, row and column lanes
// ----------------------------------------------------------------------------
module tci_divider #(
   parameter int COORD_WIDTH   = tci_pkg::COORD_WIDTH_DEF,
   parameter int MAX_DIVISIONS = tci_pkg::MAX_DIVISIONS_DEF
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  tci_pkg::tci_ctrl_type                              in_ctrl,
   input  logic [2*COORD_WIDTH+4+$clog2(MAX_DIVISIONS+1)-1:0] in_num_r,
   input  logic [2*COORD_WIDTH+4+$clog2(MAX_DIVISIONS+1)-1:0] in_num_c,
   input  logic [2*COORD_WIDTH+1:0]                           in_den,
   output tci_pkg::tci_ctrl_type                              out_ctrl,
   output logic [$clog2(MAX_DIVISIONS+1)-1:0]                 out_quo_r,
   output logic [$clog2(MAX_DIVISIONS+1)-1:0]                 out_quo_c,
   output logic [2*COORD_WIDTH+4+$clog2(MAX_DIVISIONS+1)-1:0] out_rem_r,
   output logic [2*COORD_WIDTH+4+$clog2(MAX_DIVISIONS+1)-1:0] out_rem_c,
   output logic [2*COORD_WIDTH+1:0]                           out_den
);
   import tci_pkg::*;

   localparam int XW = 2 * COORD_WIDTH + 3;
   localparam int QW = $clog2(MAX_DIVISIONS + 1);
   localparam int WW = XW + QW + 1;

   tci_ctrl_type  ctrl_ff [QW];
   logic [WW-1:0] rem_r_ff [QW];
   logic [WW-1:0] rem_c_ff [QW];
   logic [QW-1:0] quo_r_ff [QW];
   logic [QW-1:0] quo_c_ff [QW];
   logic [XW-2:0] den_ff   [QW];

   for (genvar i = 0; i < QW; i++) begin : g_stage
      localparam int B = QW - 1 - i;

      tci_ctrl_type  ctrl_src;
      logic [WW-1:0] rem_r_src, rem_c_src, rem_r_in, rem_c_in, trial;
      logic [QW-1:0] quo_r_src, quo_c_src, quo_r_in, quo_c_in;
      logic [XW-2:0] den_src;

      if (i == 0) begin : g_first
         assign ctrl_src  = in_ctrl;
         assign rem_r_src = in_num_r;
         assign rem_c_src = in_num_c;
         assign quo_r_src = '0;
         assign quo_c_src = '0;
         assign den_src   = in_den;
      end else begin : g_next
         assign ctrl_src  = ctrl_ff[i-1];
         assign rem_r_src = rem_r_ff[i-1];
         assign rem_c_src = rem_c_ff[i-1];
         assign quo_r_src = quo_r_ff[i-1];
         assign quo_c_src = quo_c_ff[i-1];
         assign den_src   = den_ff[i-1];
      end

      assign trial = WW'(den_src) << B;

      always_comb begin
         rem_r_in = rem_r_src;
         rem_c_in = rem_c_src;
         quo_r_in = quo_r_src;
         quo_c_in = quo_c_src;
         if (trial <= rem_r_src) begin
            rem_r_in    = rem_r_src - trial;
            quo_r_in[B] = 1'b1;
         end
         if (trial <= rem_c_src) begin
            rem_c_in    = rem_c_src - trial;
            quo_c_in[B] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         rem_r_ff[i] <= rem_r_in;
         rem_c_ff[i] <= rem_c_in;
         quo_r_ff[i] <= quo_r_in;
         quo_c_ff[i] <= quo_c_in;
         den_ff[i]   <= den_src;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctrl_ff[i] <= '0;
         end else begin
            ctrl_ff[i] <= ctrl_src;
         end
      end
   end

   assign out_ctrl  = ctrl_ff[QW-1];
   assign out_quo_r = quo_r_ff[QW-1];
   assign out_quo_c = quo_c_ff[QW-1];
   assign out_rem_r = rem_r_ff[QW-1];
   assign out_rem_c = rem_c_ff[QW-1];
   assign out_den   = den_ff[QW-1];

endmodule

>>> src/tci_index.sv
// ----------------------------------------------------------------------------
// tci_index
// parity of the fractions, cell number and result register
// ----------------------------------------------------------------------------
module tci_index #(
   parameter int COORD_WIDTH   = tci_pkg::COORD_WIDTH_DEF,
   parameter int MAX_DIVISIONS = tci_pkg::MAX_DIVISIONS_DEF
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  tci_pkg::tci_ctrl_type                              in_ctrl,
   input  logic [$clog2(MAX_DIVISIONS+1)-1:0]                 in_quo_r,
   input  logic [$clog2(MAX_DIVISIONS+1)-1:0]                 in_quo_c,
   input  logic [2*COORD_WIDTH+4+$clog2(MAX_DIVISIONS+1)-1:0] in_rem_r,
   input  logic [2*COORD_WIDTH+4+$clog2(MAX_DIVISIONS+1)-1:0] in_rem_c,
   input  logic [2*COORD_WIDTH+1:0]                           in_den,
   input  logic [$clog2(MAX_DIVISIONS+1)-1:0]                 divisions_eff,
   output logic                                               rsp_strobe,
   output logic [tci_pkg::IDX_W-1:0]                          rsp_cell_index,
   output logic [tci_pkg::BAND_W-1:0]                         rsp_row_band,
   output logic [tci_pkg::BAND_W-1:0]                         rsp_col_band,
   output logic                                               rsp_outside,
   output logic                                               rsp_degenerate
);
   import tci_pkg::*;

   localparam int XW   = 2 * COORD_WIDTH + 3;
   localparam int QW   = $clog2(MAX_DIVISIONS + 1);
   localparam int WW   = XW + QW + 1;
   localparam int SUMW = 2 * QW + IDX_W + 2;

   tci_ctrl_type      ca_ff, cb_ff;
   logic              par_ff;
   logic [2*QW-1:0]   rn_ff, rsq_ff;
   logic [QW-1:0]     r_ff, c_ff;
   logic [WW:0]       rem_sum;
   logic [SUMW-1:0]   sum_in;
   logic              flagged;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [BAND_W-1:0] row_ff, col_ff, row_in, col_in;

   assign rem_sum = (WW+1)'(in_rem_r) + (WW+1)'(in_rem_c);

   always_ff @(posedge clock) begin
      par_ff <= (rem_sum >= (WW+1)'(in_den));
      rn_ff  <= (2*QW)'(in_quo_r) * (2*QW)'(divisions_eff);
      rsq_ff <= (2*QW)'(in_quo_r) * (2*QW)'(in_quo_r);
      r_ff   <= in_quo_r;
      c_ff   <= in_quo_c;
   end

   // 2*r*n + 2*c - r*r + parity
   assign sum_in = (SUMW'(rn_ff) << 1) + (SUMW'(c_ff) << 1) + SUMW'(par_ff)
                   - SUMW'(rsq_ff);
   assign flagged = ca_ff.degenerate | ca_ff.outside;

   always_comb begin
      if (flagged) begin
         idx_in = '0;
         row_in = '0;
         col_in = '0;
      end else begin
         idx_in = sum_in[IDX_W-1:0];
         row_in = BAND_W'(r_ff);
         col_in = BAND_W'(c_ff);
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      row_ff <= row_in;
      col_ff <= col_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ca_ff <= '0;
         cb_ff <= '0;
      end else begin
         ca_ff <= in_ctrl;
         cb_ff <= ca_ff;
      end
   end

   assign rsp_strobe     = cb_ff.valid;
   assign rsp_cell_index = idx_ff;
   assign rsp_row_band   = row_ff;
   assign rsp_col_band   = col_ff;
   assign rsp_outside    = cb_ff.outside & ~cb_ff.degenerate;
   assign rsp_degenerate = cb_ff.degenerate;

endmodule

>>> src/triangle_cell_index.sv
// ----------------------------------------------------------------------------
// triangle_cell_index
// locates a point in a triangle cut into an n by n grid of small triangles
// ----------------------------------------------------------------------------
// usage:
//   configure the three vertices (signed q12.4) and the divisions per side
//   over the csr port while no transaction is in flight; pready is always high
//   and a write lands on the access cycle.
//   a request transaction is taken on every clock edge with start high and
//   busy low; busy is high only during reset, so one point may enter per cycle.
//   each point gives exactly one result, shown for one cycle with rsp_strobe,
//   after it has passed six stages of vector, product, cross, sign, scale
//   and inside test, one divider stage per quotient bit, and two stages for
//   the index.
//   throughput is one point per cycle.
//   the receiver cannot stall; results are not held and must be taken.
//   reset empties the pipeline and restores the default triangle
//   (0,0), (256,0), (0,256) with ten divisions.
// ----------------------------------------------------------------------------
module triangle_cell_index #(
   parameter int COORD_WIDTH   = tci_pkg::COORD_WIDTH_DEF,
   parameter int MAX_DIVISIONS = tci_pkg::MAX_DIVISIONS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [COORD_WIDTH-1:0]      req_point_x,
   input  logic signed [COORD_WIDTH-1:0]      req_point_y,
   output logic                               rsp_strobe,
   output logic [tci_pkg::IDX_W-1:0]          rsp_cell_index,
   output logic [tci_pkg::BAND_W-1:0]         rsp_row_band,
   output logic [tci_pkg::BAND_W-1:0]         rsp_col_band,
   output logic                               rsp_outside,
   output logic                               rsp_degenerate,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [tci_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [tci_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [tci_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);
   import tci_pkg::*;

   `include "triangle_cell_index_assert.svh"

   localparam int XW  = 2 * COORD_WIDTH + 3;
   localparam int NBW = $clog2(MAX_DIVISIONS + 1);
   localparam int WW  = XW + NBW + 1;
   localparam int LAT = 6 + NBW + 2;

   logic [COORD_WIDTH-1:0] ax, ay, bx, by, cx, cy;
   logic [NBW-1:0]         n_eff;
   logic                   req_take;

   tci_ctrl_type           x_ctrl, d_ctrl;
   logic [WW-1:0]          x_num_r, x_num_c, d_rem_r, d_rem_c;
   logic [XW-2:0]          x_den, d_den;
   logic [NBW-1:0]         d_quo_r, d_quo_c;
   logic                   rsp_flagged, rsp_zeroed;

   assign busy     = reset;
   assign req_take = start & ~busy;

   tci_csr #(
      .COORD_WIDTH   (COORD_WIDTH),
      .MAX_DIVISIONS (MAX_DIVISIONS)
   ) u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .vertex_a_x    (ax),
      .vertex_a_y    (ay),
      .vertex_b_x    (bx),
      .vertex_b_y    (by),
      .vertex_c_x    (cx),
      .vertex_c_y    (cy),
      .divisions_eff (n_eff)
   );

   tci_cross #(
      .COORD_WIDTH   (COORD_WIDTH),
      .MAX_DIVISIONS (MAX_DIVISIONS)
   ) u_cross (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_take),
      .point_x       (req_point_x),
      .point_y       (req_point_y),
      .vertex_a_x    (ax),
      .vertex_a_y    (ay),
      .vertex_b_x    (bx),
      .vertex_b_y    (by),
      .vertex_c_x    (cx),
      .vertex_c_y    (cy),
      .divisions_eff (n_eff),
      .out_ctrl      (x_ctrl),
      .out_num_r     (x_num_r),
      .out_num_c     (x_num_c),
      .out_den       (x_den)
   );

   tci_divider #(
      .COORD_WIDTH   (COORD_WIDTH),
      .MAX_DIVISIONS (MAX_DIVISIONS)
   ) u_divider (
      .clock         (clock),
      .reset         (reset),
      .in_ctrl       (x_ctrl),
      .in_num_r      (x_num_r),
      .in_num_c      (x_num_c),
      .in_den        (x_den),
      .out_ctrl      (d_ctrl),
      .out_quo_r     (d_quo_r),
      .out_quo_c     (d_quo_c),
      .out_rem_r     (d_rem_r),
      .out_rem_c     (d_rem_c),
      .out_den       (d_den)
   );

   tci_index #(
      .COORD_WIDTH   (COORD_WIDTH),
      .MAX_DIVISIONS (MAX_DIVISIONS)
   ) u_index (
      .clock          (clock),
      .reset          (reset),
      .in_ctrl        (d_ctrl),
      .in_quo_r       (d_quo_r),
      .in_quo_c       (d_quo_c),
      .in_rem_r       (d_rem_r),
      .in_rem_c       (d_rem_c),
      .in_den         (d_den),
      .divisions_eff  (n_eff),
      .rsp_strobe     (rsp_strobe),
      .rsp_cell_index (rsp_cell_index),
      .rsp_row_band   (rsp_row_band),
      .rsp_col_band   (rsp_col_band),
      .rsp_outside    (rsp_outside),
      .rsp_degenerate (rsp_degenerate)
   );

   assign rsp_flagged = rsp_strobe & (rsp_outside | rsp_degenerate);
   assign rsp_zeroed  = (rsp_cell_index == '0) & (rsp_row_band == '0) &
                        (rsp_col_band == '0);

   `TCI_ASSERT_DLY(a_req_to_rsp, clock, reset, req_take, LAT, rsp_strobe)
   `TCI_ASSERT_IMP(a_rsp_has_req, clock, reset, rsp_strobe, ($past(req_take, LAT)))
   `TCI_ASSERT_IMP(a_flag_zeroes, clock, reset, rsp_flagged, rsp_zeroed)
   `TCI_ASSERT_IMP(a_flags_apart, clock, reset, rsp_strobe && rsp_degenerate, !rsp_outside)

endmodule

>>> bench/triangle_cell_index_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_cell_index_checker
// follows the csr port to keep a copy of the triangle and divisions, predicts
// the cell of every accepted point and compares each result transaction
// with the oldest prediction; also checks register read data
// ----------------------------------------------------------------------------
module triangle_cell_index_checker
   import tci_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  logic [COORD_WIDTH_DEF-1:0] req_point_x,
   input  logic [COORD_WIDTH_DEF-1:0] req_point_y,
   input  logic                       rsp_strobe,
   input  logic [IDX_W-1:0]           rsp_cell_index,
   input  logic [BAND_W-1:0]          rsp_row_band,
   input  logic [BAND_W-1:0]          rsp_col_band,
   input  logic                       rsp_outside,
   input  logic                       rsp_degenerate,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [CSR_DATA_W-1:0]      csr_pwdata,
   input  logic [CSR_DATA_W-1:0]      csr_prdata,
   input  logic                       csr_pready,
   output int                         error_count,
   output int                         pending_count
);

   localparam int CW   = COORD_WIDTH_DEF;
   localparam int MAXD = MAX_DIVISIONS_DEF;

   typedef struct packed {
      logic [IDX_W-1:0]  cell_index;
      logic [BAND_W-1:0] row_band;
      logic [BAND_W-1:0] col_band;
      logic              outside;
      logic              degenerate;
   } cell_result_type;

   logic [CW-1:0]    a_x, a_y, b_x, b_y, c_x, c_y;
   logic [DIV_W-1:0] div_n;

   cell_result_type pending_cells[$];

   initial error_count = 0;
   initial pending_count = 0;

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   function automatic cell_result_type locate_cell(input logic [CW-1:0] qx,
                                                   input logic [CW-1:0] qy);
      longint org_x, org_y, e1x, e1y, e2x, e2y, vx, vy;
      longint area, num_r, num_c, n, q_r, q_c, rem_r, rem_c, idx;
      cell_result_type res;
      res   = '0;
      org_x = longint'($signed(a_x));
      org_y = longint'($signed(a_y));
      e1x   = longint'($signed(b_x)) - org_x;
      e1y   = longint'($signed(b_y)) - org_y;
      e2x   = longint'($signed(c_x)) - org_x;
      e2y   = longint'($signed(c_y)) - org_y;
      vx    = longint'($signed(qx)) - org_x;
      vy    = longint'($signed(qy)) - org_y;
      area  = e1x * e2y - e2x * e1y;
      num_r = vx * e2y - vy * e2x;
      num_c = e1x * vy - e1y * vx;
      if (area == 0) begin
         res.degenerate = 1'b1;
         return res;
      end
      // clockwise triangle: flip all signs together
      if (area < 0) begin
         area  = -area;
         num_r = -num_r;
         num_c = -num_c;
      end
      n     = (int'(div_n) > MAXD) ? MAXD : int'(div_n);
      num_r = num_r * n;
      num_c = num_c * n;
      if (num_r < 0 || num_c < 0 || num_r + num_c > area * n) begin
         res.outside = 1'b1;
         return res;
      end
      q_r   = num_r / area;
      q_c   = num_c / area;
      rem_r = num_r - q_r * area;
      rem_c = num_c - q_c * area;
      idx   = 2 * q_r * n + 2 * q_c - q_r * q_r + ((rem_r + rem_c >= area) ? 1 : 0);
      res.cell_index = IDX_W'(idx);
      res.row_band   = BAND_W'(q_r);
      res.col_band   = BAND_W'(q_c);
      return res;
   endfunction

   // register copy
   always @(posedge clock) begin
      if (reset) begin
         a_x   <= CW'(VERTEX_A_X_RST);
         a_y   <= CW'(VERTEX_A_Y_RST);
         b_x   <= CW'(VERTEX_B_X_RST);
         b_y   <= CW'(VERTEX_B_Y_RST);
         c_x   <= CW'(VERTEX_C_X_RST);
         c_y   <= CW'(VERTEX_C_Y_RST);
         div_n <= DIV_W'(DIVISIONS_RST);
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         case (csr_reg_type'(csr_paddr[4:2]))
            REG_VERTEX_A_X: a_x   <= csr_pwdata[CW-1:0];
            REG_VERTEX_A_Y: a_y   <= csr_pwdata[CW-1:0];
            REG_VERTEX_B_X: b_x   <= csr_pwdata[CW-1:0];
            REG_VERTEX_B_Y: b_y   <= csr_pwdata[CW-1:0];
            REG_VERTEX_C_X: c_x   <= csr_pwdata[CW-1:0];
            REG_VERTEX_C_Y: c_y   <= csr_pwdata[CW-1:0];
            REG_DIVISIONS:  div_n <= csr_pwdata[DIV_W-1:0];
            default: ;
         endcase
      end
   end

   always @(posedge clock) begin
      cell_result_type want;
      logic [CSR_DATA_W-1:0] stored, mask;
      logic                  known;
      if (reset) begin
         pending_cells.delete();
      end else begin
         if ($isunknown(rsp_strobe)) begin
            report_mismatch("rsp_strobe unknown");
         end else if (rsp_strobe) begin
            if (pending_cells.size() == 0) begin
               report_mismatch("result transaction with no point pending");
            end else begin
               want = pending_cells.pop_front();
               if (rsp_cell_index !== want.cell_index)
                  report_mismatch($sformatf("cell_index got %0d want %0d",
                                            rsp_cell_index, want.cell_index));
               if (rsp_row_band !== want.row_band)
                  report_mismatch($sformatf("row_band got %0d want %0d",
                                            rsp_row_band, want.row_band));
               if (rsp_col_band !== want.col_band)
                  report_mismatch($sformatf("col_band got %0d want %0d",
                                            rsp_col_band, want.col_band));
               if (rsp_outside !== want.outside)
                  report_mismatch($sformatf("outside got %b want %b",
                                            rsp_outside, want.outside));
               if (rsp_degenerate !== want.degenerate)
                  report_mismatch($sformatf("degenerate got %b want %b",
                                            rsp_degenerate, want.degenerate));
            end
         end
         if (start && !busy)
            pending_cells.push_back(locate_cell(req_point_x, req_point_y));
         if (csr_psel && csr_penable && !csr_pwrite && csr_pready) begin
            known = 1'b1;
            mask  = '1;
            mask  = mask >> (CSR_DATA_W - CW);
            case (csr_reg_type'(csr_paddr[4:2]))
               REG_VERTEX_A_X: stored = CSR_DATA_W'(a_x);
               REG_VERTEX_A_Y: stored = CSR_DATA_W'(a_y);
               REG_VERTEX_B_X: stored = CSR_DATA_W'(b_x);
               REG_VERTEX_B_Y: stored = CSR_DATA_W'(b_y);
               REG_VERTEX_C_X: stored = CSR_DATA_W'(c_x);
               REG_VERTEX_C_Y: stored = CSR_DATA_W'(c_y);
               REG_DIVISIONS: begin
                  stored = CSR_DATA_W'(div_n);
                  mask   = '1;
                  mask   = mask >> (CSR_DATA_W - DIV_W);
               end
               default: known = 1'b0;
            endcase
            if (known && (csr_prdata & mask) !== stored)
               report_mismatch($sformatf("read of address %0d got %0h want %0h",
                                         csr_paddr, csr_prdata & mask, stored));
         end
      end
      pending_count <= pending_cells.size();
   end

endmodule

>>> bench/triangle_cell_index_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triangle_cell_index_test
// drives the triangle cell index with directed corner points and then with
// random triangles and points in bursts with random gaps; a separate checker
// predicts every result and this top gives the verdict
// ----------------------------------------------------------------------------
module triangle_cell_index_test;
   import tci_pkg::*;

   localparam int CW            = COORD_WIDTH_DEF;
   localparam int COORD_MIN     = -(1 << (CW - 1));
   localparam int COORD_MAX     = (1 << (CW - 1)) - 1;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 72;
   localparam int END_WAIT      = 40;
   localparam int DRAIN_LIMIT   = 20000;
   localparam logic [CSR_ADDR_W-1:0] UNUSED_ADDR = CSR_ADDR_W'(28);

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  start       = 1'b0;
   logic                  busy;
   logic [CW-1:0]         req_point_x = '0;
   logic [CW-1:0]         req_point_y = '0;
   logic                  rsp_strobe;
   logic [IDX_W-1:0]      rsp_cell_index;
   logic [BAND_W-1:0]     rsp_row_band;
   logic [BAND_W-1:0]     rsp_col_band;
   logic                  rsp_outside;
   logic                  rsp_degenerate;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    error_count;
   int                    pending_count;

   // current triangle as written, used to aim the random points
   int tri_ax = VERTEX_A_X_RST, tri_ay = VERTEX_A_Y_RST;
   int tri_bx = VERTEX_B_X_RST, tri_by = VERTEX_B_Y_RST;
   int tri_cx = VERTEX_C_X_RST, tri_cy = VERTEX_C_Y_RST;

   triangle_cell_index dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .rsp_strobe     (rsp_strobe),
      .rsp_cell_index (rsp_cell_index),
      .rsp_row_band   (rsp_row_band),
      .rsp_col_band   (rsp_col_band),
      .rsp_outside    (rsp_outside),
      .rsp_degenerate (rsp_degenerate),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   triangle_cell_index_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .rsp_strobe     (rsp_strobe),
      .rsp_cell_index (rsp_cell_index),
      .rsp_row_band   (rsp_row_band),
      .rsp_col_band   (rsp_col_band),
      .rsp_outside    (rsp_outside),
      .rsp_degenerate (rsp_degenerate),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .error_count    (error_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic int clip_coord(input int v);
      if (v < COORD_MIN) return COORD_MIN;
      if (v > COORD_MAX) return COORD_MAX;
      return v;
   endfunction

   task automatic send_point(input int qx, input int qy);
      req_point_x <= CW'(qx);
      req_point_y <= CW'(qy);
      start       <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic pause_sender(input int cycles);
      start       <= 1'b0;
      req_point_x <= CW'($urandom);
      req_point_y <= CW'($urandom);
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_idle();
      start       <= 1'b0;
      req_point_x <= CW'($urandom);
      req_point_y <= CW'($urandom);
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic csr_access(input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data, input logic wr);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // writes every register with junk in the unused upper bits, then reads back
   task automatic set_triangle(input int ax, input int ay, input int bx, input int by,
                               input int cx, input int cy, input int div);
      int                    vals[0:REG_DIVISIONS];
      csr_reg_type           which;
      logic [CSR_DATA_W-1:0] data;
      vals[REG_VERTEX_A_X] = ax;
      vals[REG_VERTEX_A_Y] = ay;
      vals[REG_VERTEX_B_X] = bx;
      vals[REG_VERTEX_B_Y] = by;
      vals[REG_VERTEX_C_X] = cx;
      vals[REG_VERTEX_C_Y] = cy;
      vals[REG_DIVISIONS]  = div;
      which = which.first();
      do begin
         data = $urandom;
         if (which == REG_DIVISIONS)
            data[DIV_W-1:0] = DIV_W'(vals[which]);
         else
            data[CW-1:0] = CW'(vals[which]);
         csr_access({which, 2'b00}, data, 1'b1);
         which = which.next();
      end while (which != which.first());
      do begin
         csr_access({which, 2'b00}, '0, 1'b0);
         which = which.next();
      end while (which != which.first());
      tri_ax = ax; tri_ay = ay;
      tri_bx = bx; tri_by = by;
      tri_cx = cx; tri_cy = cy;
   endtask

   task automatic pick_point(output int qx, output int qy);
      int kind, u, v;
      kind = int'($urandom_range(0, 99));
      if (kind < 5) begin
         case ($urandom_range(0, 2))
            0: begin qx = tri_ax; qy = tri_ay; end
            1: begin qx = tri_bx; qy = tri_by; end
            default: begin qx = tri_cx; qy = tri_cy; end
         endcase
      end else if (kind < 85) begin
         u  = int'($urandom_range(0, 1024));
         v  = int'($urandom_range(0, 1024 - u));
         qx = tri_ax + (u * (tri_bx - tri_ax) + v * (tri_cx - tri_ax)) / 1024;
         qy = tri_ay + (u * (tri_by - tri_ay) + v * (tri_cy - tri_ay)) / 1024;
         // near-miss points around the edges
         if (kind >= 70) begin
            qx = clip_coord(qx + int'($urandom_range(0, 16)) - 8);
            qy = clip_coord(qy + int'($urandom_range(0, 16)) - 8);
         end
      end else begin
         qx = int'($signed(CW'($urandom)));
         qy = int'($signed(CW'($urandom)));
      end
   endtask

   initial begin
      int qx, qy, left, blen, span, ctr_x, ctr_y, div;
      int ax, ay, bx, by, cx, cy, waited;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset triangle, ten divisions
      send_point(0, 0);
      send_point(256, 0);
      send_point(0, 256);
      send_point(128, 128);
      send_point(-1, 0);
      send_point(0, -1);
      send_point(129, 128);
      send_point(COORD_MAX, COORD_MAX);
      send_point(COORD_MIN, COORD_MIN);
      send_point(40, 30);
      wait_idle();

      // largest triangle, most divisions
      set_triangle(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 64);
      send_point(COORD_MIN, COORD_MIN);
      send_point(COORD_MAX, COORD_MIN);
      send_point(COORD_MIN, COORD_MAX);
      send_point(0, 0);
      send_point(COORD_MAX, COORD_MAX);
      wait_idle();

      // clockwise triangle
      set_triangle(0, 0, 0, 256, 256, 0, 10);
      send_point(40, 30);
      send_point(256, 0);
      send_point(-5, 10);
      wait_idle();

      // zero area
      set_triangle(0, 0, 100, 100, 200, 200, 10);
      send_point(50, 50);
      send_point(COORD_MIN, COORD_MAX);
      wait_idle();

      // zero divisions, then above the maximum, then one
      set_triangle(0, 0, 256, 0, 0, 256, 0);
      send_point(40, 30);
      send_point(300, 300);
      wait_idle();
      set_triangle(0, 0, 256, 0, 0, 256, 127);
      send_point(40, 30);
      wait_idle();
      set_triangle(0, 0, 256, 0, 0, 256, 1);
      // write to an unused address must change nothing
      csr_access(UNUSED_ADDR, $urandom, 1'b1);
      send_point(100, 100);
      wait_idle();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case ($urandom_range(0, 2))
            0: span = COORD_MAX;
            1: span = 4000;
            default: span = 300;
         endcase
         ctr_x = int'($urandom_range(0, 65535 - 2 * span)) + COORD_MIN + span;
         ctr_y = int'($urandom_range(0, 65535 - 2 * span)) + COORD_MIN + span;
         ax = clip_coord(ctr_x + int'($urandom_range(0, 2 * span)) - span);
         ay = clip_coord(ctr_y + int'($urandom_range(0, 2 * span)) - span);
         bx = clip_coord(ctr_x + int'($urandom_range(0, 2 * span)) - span);
         by = clip_coord(ctr_y + int'($urandom_range(0, 2 * span)) - span);
         cx = clip_coord(ctr_x + int'($urandom_range(0, 2 * span)) - span);
         cy = clip_coord(ctr_y + int'($urandom_range(0, 2 * span)) - span);
         // one phase with a repeated vertex
         if (ph == 3) begin
            cx = ax;
            cy = ay;
         end
         if (ph == 0)
            div = 64;
         else if (ph == RANDOM_PHASES - 1)
            div = int'($urandom_range(0, 127));
         else
            div = int'($urandom_range(1, 64));
         set_triangle(ax, ay, bx, by, cx, cy, div);

         left = PHASE_ITEMS;
         while (left > 0) begin
            blen = int'($urandom_range(1, 24));
            while (blen > 0 && left > 0) begin
               pick_point(qx, qy);
               send_point(qx, qy);
               left--;
               blen--;
            end
            if ($urandom_range(0, 3) != 0)
               pause_sender(int'($urandom_range(1, 7)));
            if ($urandom_range(0, 15) == 0)
               wait_idle();
         end
         wait_idle();
      end

      waited = 0;
      while (pending_count != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (END_WAIT) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
